[sv/srg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, codes and constants of the stepper ramp generator.
// ----------------------------------------------------------------------------
package srg_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int POS_BITS_DEF  = 32;

    // Width of the shared divider; covers speed, stopping distance and ramp.
    localparam int DIV_W   = 48;
    localparam int SPEED_W = 20;
    localparam int STS_W   = 40;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_ACCEL     = 3'd0;
    localparam logic [2:0] REG_START     = 3'd1;
    localparam logic [2:0] REG_MIN       = 3'd2;
    localparam logic [2:0] REG_PULSE     = 3'd3;
    localparam logic [2:0] REG_DIR_INV   = 3'd4;
    localparam logic [2:0] REG_DIR_SETUP = 3'd5;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ABS    = 3'd1;
    localparam logic [2:0] MODE_REL    = 3'd2;
    localparam logic [2:0] MODE_SETPOS = 3'd3;
    localparam logic [2:0] MODE_STOP   = 3'd4;

    localparam logic [19:0] ACCEL_RST     = 20'd1;
    localparam logic [31:0] START_RST     = 32'd244738048;
    localparam logic [31:0] MIN_RST       = 32'd256;
    localparam logic [15:0] PULSE_RST     = 16'd5;
    localparam logic        DIR_INV_RST   = 1'b0;
    localparam logic [7:0]  DIR_SETUP_RST = 8'd10;

    typedef struct packed {
        logic [19:0] acceleration;
        logic [31:0] start_interval;
        logic [31:0] min_interval;
        logic [15:0] pulse_width;
        logic        dir_invert;
        logic [7:0]  dir_setup;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SD_START,
        ST_SD_DIV1,
        ST_SD_MUL,
        ST_SD_SQ,
        ST_SD_DIV2,
        ST_STOP,
        ST_DECIDE,
        ST_RAMP,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

[sv/srg_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srg_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srg_div #(
    parameter int W = srg_pkg::DIV_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic              o_done,
    output logic [W-1:0]      o_quot
);
    localparam int CW = $clog2(W);

    logic [W:0]    r_rem;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0] rem_sh;
    logic [W:0] diff;

    assign rem_sh = {r_rem[W-1:0], r_quot[W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem  <= diff;
                r_quot <= {r_quot[W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_quot <= {r_quot[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

[sv/srg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srg_regs
// APB-style configuration registers of the ramp generator.
// ----------------------------------------------------------------------------
module srg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [srg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [srg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [srg_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output srg_pkg::t_cfg                        o_cfg
);
    srg_pkg::t_cfg r_cfg;
    logic [2:0]    idx;

    assign idx    = paddr[srg_pkg::CFG_ADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.acceleration   <= srg_pkg::ACCEL_RST;
            r_cfg.start_interval <= srg_pkg::START_RST;
            r_cfg.min_interval   <= srg_pkg::MIN_RST;
            r_cfg.pulse_width    <= srg_pkg::PULSE_RST;
            r_cfg.dir_invert     <= srg_pkg::DIR_INV_RST;
            r_cfg.dir_setup      <= srg_pkg::DIR_SETUP_RST;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                srg_pkg::REG_ACCEL:     r_cfg.acceleration   <= pwdata[19:0];
                srg_pkg::REG_START:     r_cfg.start_interval <= pwdata;
                srg_pkg::REG_MIN:       r_cfg.min_interval   <= pwdata;
                srg_pkg::REG_PULSE:     r_cfg.pulse_width    <= pwdata[15:0];
                srg_pkg::REG_DIR_INV:   r_cfg.dir_invert     <= pwdata[0];
                srg_pkg::REG_DIR_SETUP: r_cfg.dir_setup      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            srg_pkg::REG_ACCEL:     prdata = {12'd0, r_cfg.acceleration};
            srg_pkg::REG_START:     prdata = r_cfg.start_interval;
            srg_pkg::REG_MIN:       prdata = r_cfg.min_interval;
            srg_pkg::REG_PULSE:     prdata = {16'd0, r_cfg.pulse_width};
            srg_pkg::REG_DIR_INV:   prdata = {31'd0, r_cfg.dir_invert};
            srg_pkg::REG_DIR_SETUP: prdata = {24'd0, r_cfg.dir_setup};
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[sv/stepper_ramp_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_ramp_generator
// Trapezoidal stepper pulse generator on the linear-acceleration recurrence.
// Sequencing: a tick without a step, or a command that leaves the ramp alone,
// goes from ST_IDLE straight to ST_DONE, where its result is registered.
// A step, move or stop runs up to three divider passes before ST_DONE.
// Sync active-low reset clears motion state and the registers.
// ----------------------------------------------------------------------------
module stepper_ramp_generator #(
    parameter int FRAC_BITS = srg_pkg::FRAC_BITS_DEF,
    parameter int POS_BITS  = srg_pkg::POS_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [srg_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [srg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [srg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [2:0]                     i_mode,
    input  wire logic signed [31:0]             i_value,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_step_level,
    output logic                                o_dir_level,
    output logic                                o_stepped,
    output logic signed [31:0]                  o_position,
    output logic signed [31:0]                  o_to_go,
    output logic                                o_running
);
    localparam int DW    = srg_pkg::DIV_W;
    localparam int SW    = srg_pkg::STS_W;
    localparam int CMP_W = (POS_BITS + 2 > SW + 2) ? POS_BITS + 2 : SW + 2;
    localparam logic [31:0] ONE_US  = 32'(1) << FRAC_BITS;
    localparam logic [DW-1:0] SPD_NUM = DW'(1000000) << FRAC_BITS;
    localparam logic signed [31:0] RI_MAX = 32'sh7FFF_FFFF;

    srg_pkg::t_cfg cfg;

    srg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic          div_start;
    logic [DW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [DW-1:0] div_quot;

    srg_div #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    srg_pkg::t_state r_state, n_state;

    logic signed [POS_BITS-1:0] r_cur, r_target;
    logic signed [31:0]         r_ri;
    logic [31:0]                r_intv, r_whole, r_since;
    logic                       r_moving, r_dir, r_ndir, r_pulse;
    logic                       r_stop, r_stepped;
    logic [srg_pkg::SPEED_W-1:0] r_speed;
    logic [2*srg_pkg::SPEED_W-1:0] r_sq;
    logic [SW-1:0]              r_sts;

    logic                       r_ovalid;
    logic                       r_o_step, r_o_dir, r_o_stepped, r_o_run;
    logic signed [31:0]         r_o_pos, r_o_togo;

    // ---------------- tick evaluation ----------------
    logic [31:0] ss1, dir_start;
    logic        tick_dir, tick_drop, tick_step;

    always_comb begin
        ss1 = (r_since == 32'hFFFF_FFFF) ? r_since : r_since + 32'd1;
        dir_start = (r_whole > {24'd0, cfg.dir_setup}) ?
                    r_whole - {24'd0, cfg.dir_setup} : 32'd0;
        tick_dir  = 1'b0;
        tick_drop = 1'b0;
        tick_step = 1'b0;
        priority if (!r_moving && !r_pulse) begin
        end else if (r_moving && (r_ndir != r_dir) && (ss1 >= dir_start)) begin
            tick_dir = 1'b1;
        end else if (r_pulse) begin
            tick_drop = (ss1 >= {16'd0, cfg.pulse_width});
        end else if (r_moving && (ss1 >= r_whole)) begin
            tick_step = 1'b1;
        end else begin
        end
    end

    // ---------------- command targets ----------------
    logic signed [POS_BITS-1:0] val_pos, tgt_abs, tgt_rel, tgt_stop, cur_step;
    logic signed [SW+1:0]       stop_off;

    assign val_pos  = POS_BITS'(i_value);
    assign tgt_abs  = val_pos;
    assign tgt_rel  = r_cur + val_pos;
    assign stop_off = r_ndir ? $signed({2'b00, r_sts} + (SW+2)'(1))
                             : -$signed({2'b00, r_sts} + (SW+2)'(1));
    assign tgt_stop = r_cur + POS_BITS'(stop_off);
    assign cur_step = r_dir ? r_cur + POS_BITS'(1) : r_cur - POS_BITS'(1);

    // ---------------- ramp decision ----------------
    logic signed [CMP_W-1:0] span, adist, sts_c;
    logic signed [31:0]      clip, ri_n;
    logic signed [34:0]      den4;
    logic [34:0]             den_abs;
    logic                    want;
    logic [31:0]             c_clamp, floor_min, start_lim;

    always_comb begin
        span  = CMP_W'(r_target) - CMP_W'(r_cur);
        adist = (span < 0) ? -span : span;
        sts_c = $signed(CMP_W'(r_sts));
        clip  = (r_sts > SW'(RI_MAX)) ? RI_MAX : $signed(r_sts[31:0]);
        want  = (span > 0);
        ri_n  = r_ri;
        if (span != 0) begin
            if ((r_ri > 0) && ((sts_c >= adist) || (r_ndir != want))) begin
                ri_n = -clip;
            end else if ((r_ri < 0) && (sts_c < adist) && (r_ndir == want)) begin
                ri_n = -r_ri;
            end
        end
        den4    = 35'(ri_n) * 35'sd4 + 35'sd1;
        den_abs = (den4 < 0) ? 35'(-den4) : 35'(den4);
        c_clamp   = (r_intv < ONE_US) ? ONE_US : r_intv;
        floor_min = (cfg.min_interval > ONE_US) ? cfg.min_interval : ONE_US;
        start_lim = (cfg.start_interval > ONE_US) ? cfg.start_interval : ONE_US;
    end

    logic signed [35:0] q_s, c_new;
    logic [31:0]        c_lim;
    logic signed [31:0] ri_inc;

    always_comb begin
        q_s   = (r_ri < 0) ? -$signed(36'(div_quot)) : $signed(36'(div_quot));
        c_new = $signed({4'd0, r_intv}) - q_s;
        if ((c_new < 0) || (c_new < $signed({4'd0, floor_min}))) begin
            c_lim = floor_min;
        end else if (c_new > 36'sh0_FFFF_FFFF) begin
            c_lim = 32'hFFFF_FFFF;
        end else begin
            c_lim = c_new[31:0];
        end
        ri_inc = (r_ri == RI_MAX) ? r_ri : r_ri + 32'sd1;
    end

    logic [20:0] two_acc;
    assign two_acc = (cfg.acceleration == '0) ? 21'd2 : {cfg.acceleration, 1'b0};

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srg_pkg::ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_mode)
                        srg_pkg::MODE_TICK:
                            n_state = tick_step ? srg_pkg::ST_SD_START : srg_pkg::ST_DONE;
                        srg_pkg::MODE_ABS:
                            n_state = (tgt_abs != r_target) ? srg_pkg::ST_SD_START
                                                            : srg_pkg::ST_DONE;
                        srg_pkg::MODE_REL:
                            n_state = (tgt_rel != r_target) ? srg_pkg::ST_SD_START
                                                            : srg_pkg::ST_DONE;
                        srg_pkg::MODE_STOP:
                            n_state = r_moving ? srg_pkg::ST_SD_START : srg_pkg::ST_DONE;
                        default:
                            n_state = srg_pkg::ST_DONE;
                    endcase
                end
            end
            srg_pkg::ST_SD_START:
                n_state = r_moving ? srg_pkg::ST_SD_DIV1 : srg_pkg::ST_DECIDE;
            srg_pkg::ST_SD_DIV1:
                if (div_done) n_state = srg_pkg::ST_SD_MUL;
            srg_pkg::ST_SD_MUL:
                n_state = srg_pkg::ST_SD_SQ;
            srg_pkg::ST_SD_SQ:
                n_state = srg_pkg::ST_SD_DIV2;
            srg_pkg::ST_SD_DIV2:
                if (div_done) n_state = r_stop ? srg_pkg::ST_STOP : srg_pkg::ST_DECIDE;
            srg_pkg::ST_STOP:
                n_state = (tgt_stop != r_target) ? srg_pkg::ST_DECIDE : srg_pkg::ST_DONE;
            srg_pkg::ST_DECIDE: begin
                if ((span == 0) && (r_sts <= SW'(1))) begin
                    n_state = srg_pkg::ST_DONE;
                end else begin
                    n_state = (ri_n == 0) ? srg_pkg::ST_DONE : srg_pkg::ST_RAMP;
                end
            end
            srg_pkg::ST_RAMP:
                if (div_done) n_state = srg_pkg::ST_DONE;
            srg_pkg::ST_DONE:
                if (!r_ovalid || i_ready) n_state = srg_pkg::ST_IDLE;
            default:
                n_state = srg_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        o_ready   = (r_state == srg_pkg::ST_IDLE);
        unique case (r_state)
            srg_pkg::ST_SD_START: begin
                div_start = r_moving;
                div_num   = SPD_NUM;
                div_den   = DW'(c_clamp);
            end
            srg_pkg::ST_SD_SQ: begin
                div_start = 1'b1;
                div_num   = DW'(r_sq);
                div_den   = DW'(two_acc);
            end
            srg_pkg::ST_DECIDE: begin
                div_start = !((span == 0) && (r_sts <= SW'(1))) && (ri_n != 0);
                div_num   = DW'({r_intv, 1'b0});
                div_den   = DW'(den_abs);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= srg_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- motion state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_target  <= '0;
            r_ri      <= '0;
            r_intv    <= '0;
            r_whole   <= '0;
            r_since   <= '0;
            r_moving  <= 1'b0;
            r_dir     <= 1'b0;
            r_ndir    <= 1'b0;
            r_pulse   <= 1'b0;
            r_stop    <= 1'b0;
            r_stepped <= 1'b0;
        end else begin
            unique case (r_state)
                srg_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_stepped <= 1'b0;
                        r_stop    <= 1'b0;
                        unique case (i_mode)
                            srg_pkg::MODE_TICK: begin
                                priority if (tick_dir) begin
                                    r_dir   <= r_ndir;
                                    r_since <= dir_start;
                                end else if (tick_step) begin
                                    r_cur     <= cur_step;
                                    r_pulse   <= 1'b1;
                                    r_since   <= '0;
                                    r_stepped <= 1'b1;
                                end else begin
                                    r_since <= ss1;
                                    if (tick_drop) r_pulse <= 1'b0;
                                end
                            end
                            srg_pkg::MODE_ABS: r_target <= tgt_abs;
                            srg_pkg::MODE_REL: r_target <= tgt_rel;
                            srg_pkg::MODE_SETPOS: begin
                                r_cur    <= val_pos;
                                r_target <= val_pos;
                                r_ri     <= '0;
                                r_whole  <= '0;
                                r_moving <= 1'b0;
                            end
                            srg_pkg::MODE_STOP: r_stop <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                srg_pkg::ST_STOP: begin
                    r_target <= tgt_stop;
                end
                srg_pkg::ST_DECIDE: begin
                    if ((span == 0) && (r_sts <= SW'(1))) begin
                        r_whole  <= '0;
                        r_moving <= 1'b0;
                        r_ri     <= '0;
                    end else if (ri_n == 0) begin
                        r_intv   <= start_lim;
                        r_whole  <= start_lim >> FRAC_BITS;
                        r_ndir   <= want;
                        r_ri     <= 32'sd1;
                        r_moving <= 1'b1;
                    end else begin
                        r_ri <= ri_n;
                    end
                end
                srg_pkg::ST_RAMP: begin
                    if (div_done) begin
                        r_intv   <= c_lim;
                        r_whole  <= c_lim >> FRAC_BITS;
                        r_ri     <= ri_inc;
                        r_moving <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Stopping distance pipeline: speed, its square, then the distance.
    always_ff @(posedge i_clk) begin
        if (r_state == srg_pkg::ST_SD_START && !r_moving) r_sts <= '0;
        if (r_state == srg_pkg::ST_SD_DIV1 && div_done)
            r_speed <= div_quot[srg_pkg::SPEED_W-1:0];
        if (r_state == srg_pkg::ST_SD_MUL) r_sq <= r_speed * r_speed;
        if (r_state == srg_pkg::ST_SD_DIV2 && div_done) r_sts <= div_quot[SW-1:0];
    end

    // ---------------- result register ----------------
    logic signed [CMP_W-1:0] togo_w;
    logic signed [31:0]      togo_sat;

    always_comb begin
        togo_w = CMP_W'(r_target) - CMP_W'(r_cur);
        if (togo_w > CMP_W'(RI_MAX)) begin
            togo_sat = RI_MAX;
        end else if (togo_w < -CMP_W'(RI_MAX) - CMP_W'(1)) begin
            togo_sat = 32'sh8000_0000;
        end else begin
            togo_sat = togo_w[31:0];
        end
    end

    logic out_load;
    assign out_load = (r_state == srg_pkg::ST_DONE) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_step    <= r_pulse;
            r_o_dir     <= r_dir ^ cfg.dir_invert;
            r_o_stepped <= r_stepped;
            r_o_pos     <= 32'(r_cur);
            r_o_togo    <= togo_sat;
            r_o_run     <= r_moving || (togo_sat != 0) || r_pulse;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_step_level = r_o_step;
    assign o_dir_level  = r_o_dir;
    assign o_stepped    = r_o_stepped;
    assign o_position   = r_o_pos;
    assign o_to_go      = r_o_togo;
    assign o_running    = r_o_run;

endmodule
`default_nettype wire
